>>> src/go_to_target_mission_sequencer_unit_macros.svh
// Assertion macros for the go-to-target mission sequencer unit.
`ifndef GO_TO_TARGET_MISSION_SEQUENCER_UNIT_MACROS_SVH
`define GO_TO_TARGET_MISSION_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every aclk edge out of reset.
`define GTMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gtms assertion failed");
// Next-cycle implication, checked at every aclk edge out of reset.
`define GTMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gtms assertion failed");
`else
`define GTMS_ASSERT_NOW(lbl, ante, cons)
`define GTMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/gtms_pkg.sv
// Shared types and constants of the go-to-target mission sequencer unit.
package gtms_pkg;

    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned S_TUSER_W = 5;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] MISSION_TIMEOUT_RST = 32'd30000;
    localparam logic [31:0] LINK_TIMEOUT_RST = 32'd1000;
    localparam logic [31:0] RADIUS_SQ_RST = 32'd10000;   // 100 mm squared

    localparam logic [7:0] NACK_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        MS_IDLE      = 3'd0,
        MS_DRIVING   = 3'd1,
        MS_AT_TARGET = 3'd2,
        MS_RETURNING = 3'd3,
        MS_ERROR     = 3'd4
    } mission_state_t;

    typedef enum logic [1:0] {
        LS_DISCONNECTED = 2'd0,
        LS_CONNECTED    = 2'd1,
        LS_TIMED_OUT    = 2'd2
    } link_state_t;

    typedef enum logic [1:0] {
        LC_NONE   = 2'd0,
        LC_DRIVE  = 2'd1,
        LC_STOP   = 2'd2,
        LC_RETURN = 2'd3
    } link_cmd_t;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_START   = 3'd1,
        MODE_STOP    = 3'd2,
        MODE_RETURN  = 3'd3,
        MODE_CAPTURE = 3'd4,
        MODE_RESET   = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MISSION_TIMEOUT = 2'd0,
        CFG_LINK_TIMEOUT    = 2'd1,
        CFG_ARRIVAL_RADIUS  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [2:0]         mode;
        logic signed [15:0] goal_x_mm;
        logic signed [15:0] goal_y_mm;
        logic               pos_valid;
        logic signed [15:0] pos_x_mm;
        logic signed [15:0] pos_y_mm;
        logic               poll_received;
        logic [7:0]         poll_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] mission_timeout_ms;
        logic [31:0] link_timeout_ms;
        logic [31:0] radius_sq;
    } cfg_t;

    typedef struct packed {
        link_cmd_t          link_cmd;
        logic signed [15:0] link_x_mm;
        logic signed [15:0] link_y_mm;
        logic               stop_after;
        mission_state_t     mission_state_out;
        link_state_t        link_state_out;
        logic               acknowledged;
        logic [15:0]        missions_started;
        logic [15:0]        errors_seen;
    } result_t;

endpackage

>>> src/gtms_in_stage.sv
// Input register stage: captures one update pass transaction.
module gtms_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gtms_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gtms_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           take,
    output logic                           item_valid,
    output gtms_pkg::item_t                item
);

    logic            valid_reg;
    gtms_pkg::item_t item_reg;
    gtms_pkg::item_t item_next;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        item_next.now_ms        = s_tdata[31:0];
        item_next.goal_x_mm     = s_tdata[47:32];
        item_next.goal_y_mm     = s_tdata[63:48];
        item_next.pos_x_mm      = s_tdata[79:64];
        item_next.pos_y_mm      = s_tdata[95:80];
        item_next.poll_byte     = s_tdata[103:96];
        item_next.mode          = s_tuser[2:0];
        item_next.pos_valid     = s_tuser[3];
        item_next.poll_received = s_tuser[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> src/gtms_cfg_regs.sv
// Configuration registers; the arrival radius is kept squared.
module gtms_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gtms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtms_pkg::CFG_DATA_W-1:0] cfg_data,
    output gtms_pkg::cfg_t                  cfg
);

    logic [31:0] mission_timeout_reg;
    logic [31:0] link_timeout_reg;
    logic [31:0] radius_sq_reg;
    logic [15:0] radius;
    logic [31:0] radius_sq;

    assign cfg_ready = 1'b1;
    assign radius    = cfg_data[15:0];
    assign radius_sq = 32'(radius) * 32'(radius);

    assign cfg.mission_timeout_ms = mission_timeout_reg;
    assign cfg.link_timeout_ms    = link_timeout_reg;
    assign cfg.radius_sq          = radius_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mission_timeout_reg <= gtms_pkg::MISSION_TIMEOUT_RST;
            link_timeout_reg    <= gtms_pkg::LINK_TIMEOUT_RST;
            radius_sq_reg       <= gtms_pkg::RADIUS_SQ_RST;
        end else if (cfg_valid) begin
            case (gtms_pkg::cfg_idx_t'(cfg_index))
                gtms_pkg::CFG_MISSION_TIMEOUT: mission_timeout_reg <= cfg_data[31:0];
                gtms_pkg::CFG_LINK_TIMEOUT:    link_timeout_reg    <= cfg_data[31:0];
                gtms_pkg::CFG_ARRIVAL_RADIUS:  radius_sq_reg       <= radius_sq;
                default: ;
            endcase
        end
    end

endmodule

>>> src/gtms_core.sv
// Mission and link state with the single-pass update logic.
`include "go_to_target_mission_sequencer_unit_macros.svh"
module gtms_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  gtms_pkg::item_t   item,
    input  gtms_pkg::cfg_t    cfg,
    output gtms_pkg::result_t res
);

    gtms_pkg::mission_state_t ms_reg, ms_next, ms_cmd;
    gtms_pkg::link_state_t    ls_reg, ls_next;
    logic [31:0]        entry_reg, entry_next;
    logic [31:0]        heard_time_reg, heard_time_next;
    logic               heard_reg, heard_next;
    logic signed [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [15:0] goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic signed [15:0] home_x_reg, home_x_next, home_y_reg, home_y_next;
    logic               ack_reg, ack_next;
    logic [15:0]        mcnt_reg, mcnt_next;
    logic [15:0]        ecnt_reg, ecnt_next;

    logic [31:0]        in_state;
    logic [31:0]        entry_cmd;
    logic signed [15:0] tgt_x, tgt_y;
    logic signed [16:0] dx, dy;
    logic [16:0]        ax, ay;
    logic [33:0]        dist_sq;
    logic               arrived;
    logic               fail;

    always_comb begin
        ms_next         = ms_reg;
        ls_next         = ls_reg;
        heard_time_next = heard_time_reg;
        heard_next      = heard_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        home_x_next     = home_x_reg;
        home_y_next     = home_y_reg;
        ack_next        = ack_reg;
        mcnt_next       = mcnt_reg;
        ecnt_next       = ecnt_reg;
        res             = '0;
        fail            = 1'b0;

        // position update
        cur_x_next = item.pos_valid ? item.pos_x_mm : cur_x_reg;
        cur_y_next = item.pos_valid ? item.pos_y_mm : cur_y_reg;

        // link: poll result, then silence watchdog
        if (item.poll_received) begin
            heard_time_next = item.now_ms;
            heard_next      = 1'b1;
            ls_next         = gtms_pkg::LS_CONNECTED;
            ack_next        = (item.poll_byte != gtms_pkg::NACK_BYTE);
        end
        if (heard_next && ((item.now_ms - heard_time_next) >= cfg.link_timeout_ms)) begin
            ls_next = gtms_pkg::LS_TIMED_OUT;
        end

        // command phase
        case (gtms_pkg::mode_t'(item.mode))
            gtms_pkg::MODE_START: begin
                if (ms_reg == gtms_pkg::MS_IDLE || ms_reg == gtms_pkg::MS_AT_TARGET) begin
                    goal_x_next   = item.goal_x_mm;
                    goal_y_next   = item.goal_y_mm;
                    res.link_cmd  = gtms_pkg::LC_DRIVE;
                    res.link_x_mm = item.goal_x_mm;
                    res.link_y_mm = item.goal_y_mm;
                    ack_next      = 1'b0;
                    mcnt_next     = mcnt_reg + 16'd1;
                    ms_next       = gtms_pkg::MS_DRIVING;
                end
            end
            gtms_pkg::MODE_STOP: begin
                res.link_cmd = gtms_pkg::LC_STOP;
                ms_next      = gtms_pkg::MS_IDLE;
            end
            gtms_pkg::MODE_RETURN: begin
                if (ms_reg != gtms_pkg::MS_ERROR) begin
                    goal_x_next   = home_x_reg;
                    goal_y_next   = home_y_reg;
                    res.link_cmd  = gtms_pkg::LC_RETURN;
                    res.link_x_mm = home_x_reg;
                    res.link_y_mm = home_y_reg;
                    ack_next      = 1'b0;
                    ms_next       = gtms_pkg::MS_RETURNING;
                end
            end
            gtms_pkg::MODE_CAPTURE: begin
                home_x_next = cur_x_next;
                home_y_next = cur_y_next;
                ms_next     = gtms_pkg::MS_IDLE;
            end
            gtms_pkg::MODE_RESET: begin
                res.link_cmd = gtms_pkg::LC_STOP;
                ms_next      = gtms_pkg::MS_IDLE;
                mcnt_next    = 16'd0;
                ecnt_next    = 16'd0;
                ls_next      = gtms_pkg::LS_DISCONNECTED;
            end
            default: ;
        endcase

        ms_cmd    = ms_next;
        entry_cmd = (ms_cmd != ms_reg) ? item.now_ms : entry_reg;
        in_state  = item.now_ms - entry_cmd;

        // arrival: squared distance against squared radius
        tgt_x   = (ms_cmd == gtms_pkg::MS_DRIVING) ? goal_x_next : home_x_next;
        tgt_y   = (ms_cmd == gtms_pkg::MS_DRIVING) ? goal_y_next : home_y_next;
        dx      = 17'(cur_x_next) - 17'(tgt_x);
        dy      = 17'(cur_y_next) - 17'(tgt_y);
        ax      = dx[16] ? 17'(-dx) : 17'(dx);
        ay      = dy[16] ? 17'(-dy) : 17'(dy);
        dist_sq = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
        arrived = (dist_sq <= {2'b00, cfg.radius_sq});

        // state phase
        if (ms_cmd == gtms_pkg::MS_DRIVING || ms_cmd == gtms_pkg::MS_RETURNING) begin
            if (arrived) begin
                res.stop_after = 1'b1;
                ms_next = (ms_cmd == gtms_pkg::MS_DRIVING) ? gtms_pkg::MS_AT_TARGET
                                                           : gtms_pkg::MS_IDLE;
            end else if (in_state >= cfg.mission_timeout_ms) begin
                fail = 1'b1;
            end else if (ls_next == gtms_pkg::LS_TIMED_OUT) begin
                fail = 1'b1;
            end
            if (fail) begin
                res.stop_after = 1'b1;
                ecnt_next      = ecnt_next + 16'd1;
                ms_next        = gtms_pkg::MS_ERROR;
            end
        end

        entry_next = (ms_next != ms_cmd) ? item.now_ms : entry_cmd;

        res.mission_state_out = ms_next;
        res.link_state_out    = ls_next;
        res.acknowledged      = ack_next;
        res.missions_started  = mcnt_next;
        res.errors_seen       = ecnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg         <= gtms_pkg::MS_IDLE;
            ls_reg         <= gtms_pkg::LS_DISCONNECTED;
            entry_reg      <= '0;
            heard_time_reg <= '0;
            heard_reg      <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            home_x_reg     <= '0;
            home_y_reg     <= '0;
            ack_reg        <= 1'b0;
            mcnt_reg       <= '0;
            ecnt_reg       <= '0;
        end else if (fire) begin
            ms_reg         <= ms_next;
            ls_reg         <= ls_next;
            entry_reg      <= entry_next;
            heard_time_reg <= heard_time_next;
            heard_reg      <= heard_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            home_x_reg     <= home_x_next;
            home_y_reg     <= home_y_next;
            ack_reg        <= ack_next;
            mcnt_reg       <= mcnt_next;
            ecnt_reg       <= ecnt_next;
        end
    end

    // a reset command leaves both counters at zero
    `GTMS_ASSERT_NEXT(a_reset_clears_counts, fire && item.mode == gtms_pkg::MODE_RESET, mcnt_reg == 16'd0 && ecnt_reg == 16'd0)
    // a stop from the state phase always lands in a resting state
    `GTMS_ASSERT_NOW(a_stop_after_rest, fire && res.stop_after, res.mission_state_out == gtms_pkg::MS_IDLE || res.mission_state_out == gtms_pkg::MS_AT_TARGET || res.mission_state_out == gtms_pkg::MS_ERROR)
    // coordinates only go out with drive or return
    `GTMS_ASSERT_NOW(a_idle_coords_zero, res.link_cmd == gtms_pkg::LC_NONE || res.link_cmd == gtms_pkg::LC_STOP, res.link_x_mm == 16'sd0 && res.link_y_mm == 16'sd0)
    // error count moves by one at most, or is cleared
    `GTMS_ASSERT_NEXT(a_err_count_step, fire, ecnt_reg == $past(ecnt_reg) || ecnt_reg == $past(ecnt_reg) + 16'd1 || ecnt_reg == 16'd0)

endmodule

>>> src/gtms_out_stage.sv
// Result register stage feeding the master-side stream.
module gtms_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  gtms_pkg::result_t              res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gtms_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                           valid_reg;
    logic [gtms_pkg::M_TDATA_W-1:0] data_reg;
    logic [gtms_pkg::M_TDATA_W-1:0] data_next;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    assign data_next = {7'd0, res.errors_seen, res.missions_started, res.acknowledged,
                        res.link_state_out, res.mission_state_out, res.stop_after,
                        res.link_y_mm, res.link_x_mm, res.link_cmd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/go_to_target_mission_sequencer_unit.sv
// Top level of the go-to-target mission sequencer unit.
//
// Each s_ transaction is one update pass of a go-to-target mission: it may bring a
// new position, a status poll result and a command, and it yields exactly one m_
// transaction with the link command sent, the mission and link states and the
// counters. The unit accepts one pass per clock cycle while the m_ side is not
// stalled; a pass is held in the input register and its result is loaded into
// the result register, from which it is valid on the m_ side. The mission state
// update is combinational within a pass, so the next pass can follow at once; a
// stalled m_ side holds the pass in the input register.
// Arrival compares the squared distance with the squared radius, which is computed
// once when the radius register is written. Configuration writes are taken in any
// cycle and must only be issued while no pass is in flight.
module go_to_target_mission_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // update pass stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], goal_x_mm[47:32], goal_y_mm[63:48], pos_x_mm[79:64],
    // pos_y_mm[95:80], poll_byte[103:96]
    input  logic [gtms_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[2:0], pos_valid[3], poll_received[4]
    input  logic [gtms_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // link_cmd[1:0], link_x_mm[17:2], link_y_mm[33:18], stop_after[34],
    // mission_state_out[37:35], link_state_out[39:38], acknowledged[40],
    // missions_started[56:41], errors_seen[72:57], zero pad[79:73]
    output logic [gtms_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gtms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtms_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic              item_valid;
    logic              fire;
    gtms_pkg::item_t   item;
    gtms_pkg::cfg_t    cfg;
    gtms_pkg::result_t res;

    // a pass is processed when the result register is free or draining
    assign fire = item_valid && (!m_tvalid || m_tready);

    gtms_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    gtms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gtms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    gtms_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
